// ----- hdl/qte_pkg.sv -----
// qte_pkg: shared types, constants and tables for the quaternion to euler unit
// no dependencies

package qte_pkg;

    // widths of the internal datapath
    localparam int unsigned NormW  = 35;   // squared norm, unsigned Q4.28 up to 2^32
    localparam int unsigned VecW   = 40;   // cordic vector lanes, signed
    localparam int unsigned AccW   = 28;   // angle accumulator, deg with 16 fraction bits
    localparam int unsigned SqrtW  = 63;   // radicand of the pitch cosine, up to 2^62
    localparam int unsigned RootW  = 32;   // square root result, up to 2^31
    localparam int unsigned TabLen = 24;

    localparam logic signed [AccW-1:0] Deg180 = AccW'(180 * 65536);
    localparam int Out180 = 23040;
    localparam int Out90  = 11520;

    // per-lane state that travels down the cordic cells
    typedef struct packed {
        logic signed [VecW-1:0] x;
        logic signed [VecW-1:0] y;
        logic signed [AccW-1:0] z;
    } t_lane;

    // item side information carried alongside the lanes
    typedef struct packed {
        logic gimbal;
        logic degen;
        logic pitch_neg;
    } t_side;

    function automatic logic signed [AccW-1:0] atan_entry(input int unsigned i);
        logic signed [AccW-1:0] v;
        case (i)
            0: v = AccW'(2949120);
            1: v = AccW'(1740967);
            2: v = AccW'(919879);
            3: v = AccW'(466945);
            4: v = AccW'(234379);
            5: v = AccW'(117304);
            6: v = AccW'(58666);
            7: v = AccW'(29335);
            8: v = AccW'(14668);
            9: v = AccW'(7334);
            10: v = AccW'(3667);
            11: v = AccW'(1833);
            12: v = AccW'(917);
            13: v = AccW'(458);
            14: v = AccW'(229);
            15: v = AccW'(115);
            16: v = AccW'(57);
            17: v = AccW'(29);
            18: v = AccW'(14);
            19: v = AccW'(7);
            20: v = AccW'(4);
            21: v = AccW'(2);
            22: v = AccW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- hdl/quaternion_to_euler_angles_unit.sv -----
// quaternion_to_euler_angles_unit: top level, front end, square root and cordic chains
// depends on qte_pkg, qte_isqrt_cell, qte_cordic_cell
//
// channel  | dir | tdata fields (low bit first)                    | tuser
// s_axis   | in  | quat_w[15:0] quat_x[31:16] quat_y[47:32] z[63:48] | none
// m_axis   | out | roll[15:0] pitch[30:16] yaw[46:31] gimbal[47]     | none
//          |     | degenerate[48], zero fill to 56 bits              |
// cfg      | in  | i_cfg_we, i_cfg_wdata = min_norm_squared[32:0]    |
//
// one quaternion per cycle is accepted while the output is not stalled; an item passes through
// the five front end stages, the 32 square root cells, the pre-rotation register,
// the cordic cell chain and the output register
// reset clears the valid bits of every cell and the output register; threshold goes to 1
// a stalled output freezes the whole chain; s_axis_tready follows m_axis_tready or an
// empty output register

module quaternion_to_euler_angles_unit #(
    parameter int unsigned CORDIC_STAGES   = 16,
    parameter int unsigned COMPONENT_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [4*COMPONENT_WIDTH-1:0] s_axis_tdata,   // w, x, y, z from low bits
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [55:0]                  m_axis_tdata,   // roll, pitch, yaw, gimbal, degen
    input  logic                         i_cfg_we,
    input  logic [32:0]                  i_cfg_wdata     // min_norm_squared
);

    localparam int unsigned Cw     = COMPONENT_WIDTH;
    localparam int unsigned Stages = (CORDIC_STAGES < qte_pkg::TabLen) ?
                                     CORDIC_STAGES : qte_pkg::TabLen;
    localparam int unsigned RootW  = qte_pkg::RootW;
    localparam int unsigned SqrtW  = qte_pkg::SqrtW;
    localparam int unsigned VecW   = qte_pkg::VecW;
    localparam int unsigned AccW   = qte_pkg::AccW;

    logic                r_cfg_min;
    logic [32:0]         r_min_norm;
    logic                en;

    // output register with stall
    logic                r_out_valid;
    logic [55:0]         r_out_data;

    assign en            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_norm <= 33'd1;
            r_cfg_min  <= 1'b0;
        end else if (i_cfg_we) begin
            r_min_norm <= i_cfg_wdata;
            r_cfg_min  <= 1'b1;
        end
    end

    // components to Q1.14
    logic signed [15:0] q [4];
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (Cw >= 16) begin
                q[k] = 16'(signed'(s_axis_tdata[k*Cw +: Cw]) >>> (Cw - 16));
            end else begin
                q[k] = 16'(signed'(s_axis_tdata[k*Cw +: Cw])) <<< (16 - Cw);
            end
        end
    end

    // stage 1: register components
    logic               r1_v;
    logic signed [15:0] r1_q [4];
    // stage 2: products
    logic               r2_v;
    logic signed [31:0] r2_ww, r2_xx, r2_yy, r2_zz, r2_wx, r2_yz, r2_wz, r2_xy, r2_wy, r2_zx;
    // stage 3: sums
    logic                        r3_v;
    logic signed [35:0]          r3_n, r3_sr, r3_cr, r3_sy, r3_cy, r3_sp;
    // stage 4: compare and radicand factors
    logic                        r4_v;
    qte_pkg::t_side              r4_side;
    qte_pkg::t_lane              r4_lane [3];
    logic [32:0]                 r4_d, r4_e;
    // stage 5: radicand product
    logic                        r5_v;
    qte_pkg::t_side              r5_side;
    qte_pkg::t_lane              r5_lane [3];
    logic [SqrtW-1:0]            r5_rad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0; r2_v <= 1'b0; r3_v <= 1'b0; r4_v <= 1'b0; r5_v <= 1'b0;
        end else if (en) begin
            r1_v <= s_axis_tvalid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
    end

    logic signed [35:0] asp;
    logic               degen;
    always_comb begin
        asp   = r3_sp[35] ? -r3_sp : r3_sp;
        degen = !(r3_n > signed'({3'b000, r_min_norm}));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_q  <= q;
            r2_ww <= r1_q[0] * r1_q[0];
            r2_xx <= r1_q[1] * r1_q[1];
            r2_yy <= r1_q[2] * r1_q[2];
            r2_zz <= r1_q[3] * r1_q[3];
            r2_wx <= r1_q[0] * r1_q[1];
            r2_yz <= r1_q[2] * r1_q[3];
            r2_wz <= r1_q[0] * r1_q[3];
            r2_xy <= r1_q[1] * r1_q[2];
            r2_wy <= r1_q[0] * r1_q[2];
            r2_zx <= r1_q[3] * r1_q[1];
            r3_n  <= 36'(r2_ww) + 36'(r2_xx) + 36'(r2_yy) + 36'(r2_zz);
            r3_sr <= (36'(r2_wx) + 36'(r2_yz)) <<< 1;
            r3_cr <= 36'(r2_ww) + 36'(r2_zz) - 36'(r2_xx) - 36'(r2_yy);
            r3_sy <= (36'(r2_wz) + 36'(r2_xy)) <<< 1;
            r3_cy <= 36'(r2_ww) + 36'(r2_xx) - 36'(r2_yy) - 36'(r2_zz);
            r3_sp <= (36'(r2_wy) - 36'(r2_zx)) <<< 1;
            // lanes: roll, yaw, pitch (pitch x filled after the root)
            r4_side.degen     <= degen;
            r4_side.gimbal    <= !degen && (asp >= r3_n);
            r4_side.pitch_neg <= r3_sp[35];
            r4_lane[0].x <= VecW'(r3_cr);
            r4_lane[0].y <= VecW'(r3_sr);
            r4_lane[0].z <= '0;
            r4_lane[1].x <= VecW'(r3_cy);
            r4_lane[1].y <= VecW'(r3_sy);
            r4_lane[1].z <= '0;
            r4_lane[2].x <= '0;
            r4_lane[2].y <= VecW'(r3_sp);
            r4_lane[2].z <= '0;
            r4_d <= (asp >= r3_n) ? '0 : 33'((r3_n - asp) >>> 1);
            r4_e <= (asp >= r3_n) ? '0 : 33'((r3_n + asp) >>> 1);
            r5_side <= r4_side;
            r5_lane <= r4_lane;
            // d*e is at most (n/2)^2 <= 2^62
            r5_rad  <= SqrtW'(66'(r4_d) * 66'(r4_e));
        end
    end

    // square root chain
    logic                  sq_v    [RootW+1];
    logic [SqrtW-1:0]      sq_rem  [RootW+1];
    logic [RootW-1:0]      sq_root [RootW+1];
    qte_pkg::t_lane        sq_lane [RootW+1][3];
    qte_pkg::t_side        sq_side [RootW+1];

    assign sq_v[0]    = r5_v;
    assign sq_rem[0]  = r5_rad;
    assign sq_root[0] = '0;
    assign sq_lane[0] = r5_lane;
    assign sq_side[0] = r5_side;

    for (genvar g = 0; g < RootW; g++) begin : g_sqrt
        qte_isqrt_cell #(.STEP(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (sq_v[g]),
            .i_rem   (sq_rem[g]),
            .i_root  (sq_root[g]),
            .i_lane  (sq_lane[g]),
            .i_side  (sq_side[g]),
            .o_valid (sq_v[g+1]),
            .o_rem   (sq_rem[g+1]),
            .o_root  (sq_root[g+1]),
            .o_lane  (sq_lane[g+1]),
            .o_side  (sq_side[g+1])
        );
    end

    // pre-rotation for negative x and pitch cosine insertion
    logic               r6_v;
    qte_pkg::t_lane     r6_lane [3];
    qte_pkg::t_side     r6_side;
    qte_pkg::t_lane     pre [3];
    always_comb begin
        pre = sq_lane[RootW];
        pre[2].x = VecW'({sq_root[RootW], 1'b0});
        for (int k = 0; k < 3; k++) begin
            if (pre[k].x[VecW-1]) begin
                pre[k].z = pre[k].y[VecW-1] ? -qte_pkg::Deg180 : qte_pkg::Deg180;
                pre[k].x = -pre[k].x;
                pre[k].y = -pre[k].y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (en) begin
            r6_v <= sq_v[RootW];
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_lane <= pre;
            r6_side <= sq_side[RootW];
        end
    end

    // cordic chain
    logic               cd_v    [Stages+1];
    qte_pkg::t_lane     cd_lane [Stages+1][3];
    qte_pkg::t_side     cd_side [Stages+1];
    assign cd_v[0]    = r6_v;
    assign cd_lane[0] = r6_lane;
    assign cd_side[0] = r6_side;

    for (genvar g = 0; g < Stages; g++) begin : g_cordic
        qte_cordic_cell #(.STAGE(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (cd_v[g]),
            .i_lane  (cd_lane[g]),
            .i_side  (cd_side[g]),
            .o_valid (cd_v[g+1]),
            .o_lane  (cd_lane[g+1]),
            .o_side  (cd_side[g+1])
        );
    end

    // rounding, saturation and special cases
    logic signed [AccW-1:0] rnd [3];
    logic signed [AccW-1:0] ang [3];
    logic                   zero_in [3];
    logic [55:0]            n_out;
    qte_pkg::t_side         fs;
    logic signed [15:0]     roll_o, yaw_o;
    logic signed [14:0]     pitch_o;

    // remember which lanes started from the zero vector
    logic r_zero [Stages][3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            zero_in[k] = (r6_lane[k].x == '0) && (r6_lane[k].y == '0);
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_zero[0] <= zero_in;
            for (int s = 1; s < Stages; s++) begin
                r_zero[s] <= r_zero[s-1];
            end
        end
    end

    always_comb begin
        fs = cd_side[Stages];
        for (int k = 0; k < 3; k++) begin
            rnd[k] = (cd_lane[Stages][k].z + AccW'(256)) >>> 9;
            ang[k] = r_zero[Stages-1][k] ? '0 : rnd[k];
        end
        roll_o  = (ang[0] > AccW'(qte_pkg::Out180)) ? 16'(qte_pkg::Out180) :
                  (ang[0] < -AccW'(qte_pkg::Out180)) ? -16'(qte_pkg::Out180) : 16'(ang[0]);
        yaw_o   = (ang[1] > AccW'(qte_pkg::Out180)) ? 16'(qte_pkg::Out180) :
                  (ang[1] < -AccW'(qte_pkg::Out180)) ? -16'(qte_pkg::Out180) : 16'(ang[1]);
        pitch_o = (ang[2] > AccW'(qte_pkg::Out90)) ? 15'(qte_pkg::Out90) :
                  (ang[2] < -AccW'(qte_pkg::Out90)) ? -15'(qte_pkg::Out90) : 15'(ang[2]);
        if (fs.gimbal) begin
            pitch_o = fs.pitch_neg ? -15'(qte_pkg::Out90) : 15'(qte_pkg::Out90);
        end
        if (fs.degen) begin
            roll_o = '0; yaw_o = '0; pitch_o = '0;
        end
        n_out = {7'd0, fs.degen, fs.gimbal, yaw_o, pitch_o, roll_o};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= cd_v[Stages];
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data <= n_out;
        end
    end

    // a stalled result holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed under stall");
    // degenerate results carry zero angles and no gimbal flag
    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[48]) |-> (m_axis_tdata[47:0] == '0))
        else $error("degenerate result with nonzero angles");
    // gimbal lock forces pitch to plus or minus 90 degrees
    a_gimbal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[47]) |->
        (m_axis_tdata[30:16] == 15'(qte_pkg::Out90) ||
         m_axis_tdata[30:16] == -15'(qte_pkg::Out90)))
        else $error("gimbal lock without quarter turn pitch");
    // the threshold register is written as configured
    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_min_norm == $past(i_cfg_wdata) && r_cfg_min))
        else $error("threshold write lost");

endmodule

// ----- hdl/qte_cordic_cell.sv -----
// qte_cordic_cell: one vectoring cordic iteration for three lanes
// depends on qte_pkg

module qte_cordic_cell #(
    parameter int unsigned STAGE = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  qte_pkg::t_lane  i_lane [3],
    input  qte_pkg::t_side  i_side,
    output logic            o_valid,
    output qte_pkg::t_lane  o_lane [3],
    output qte_pkg::t_side  o_side
);

    localparam logic signed [qte_pkg::AccW-1:0] Ang = qte_pkg::atan_entry(STAGE);

    logic            r_valid;
    qte_pkg::t_lane  r_lane [3];
    qte_pkg::t_side  r_side;
    qte_pkg::t_lane  n_lane [3];

    // rotate each lane toward the x axis
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (!i_lane[k].y[qte_pkg::VecW-1]) begin
                n_lane[k].x = i_lane[k].x + (i_lane[k].y >>> STAGE);
                n_lane[k].y = i_lane[k].y - (i_lane[k].x >>> STAGE);
                n_lane[k].z = i_lane[k].z + Ang;
            end else begin
                n_lane[k].x = i_lane[k].x - (i_lane[k].y >>> STAGE);
                n_lane[k].y = i_lane[k].y + (i_lane[k].x >>> STAGE);
                n_lane[k].z = i_lane[k].z - Ang;
            end
        end
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;
    assign o_side  = r_side;

endmodule

// ----- hdl/qte_isqrt_cell.sv -----
// qte_isqrt_cell: one restoring square root step with a delay lane for the angle inputs
// depends on qte_pkg

module qte_isqrt_cell #(
    parameter int unsigned STEP = 0
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic [qte_pkg::SqrtW-1:0]      i_rem,
    input  logic [qte_pkg::RootW-1:0]      i_root,
    input  qte_pkg::t_lane                 i_lane [3],
    input  qte_pkg::t_side                 i_side,
    output logic                           o_valid,
    output logic [qte_pkg::SqrtW-1:0]      o_rem,
    output logic [qte_pkg::RootW-1:0]      o_root,
    output qte_pkg::t_lane                 o_lane [3],
    output qte_pkg::t_side                 o_side
);

    // result bit decided in this step
    localparam int unsigned Bit = qte_pkg::RootW - 1 - STEP;

    logic                          r_valid;
    logic [qte_pkg::SqrtW-1:0]     r_rem;
    logic [qte_pkg::RootW-1:0]     r_root;
    qte_pkg::t_lane                r_lane [3];
    qte_pkg::t_side                r_side;
    logic [qte_pkg::SqrtW+1:0]     trial;
    logic [qte_pkg::SqrtW-1:0]     n_rem;
    logic [qte_pkg::RootW-1:0]     n_root;

    // try setting the bit: (root + 2^b)^2 - root^2 = 2^b (2 root + 2^b)
    always_comb begin
        trial = ((qte_pkg::SqrtW+2)'(i_root) << (Bit + 1))
              + ((qte_pkg::SqrtW+2)'(1) << (2 * Bit));
        if ((qte_pkg::SqrtW+2)'(i_rem) >= trial) begin
            n_rem  = qte_pkg::SqrtW'((qte_pkg::SqrtW+2)'(i_rem) - trial);
            n_root = i_root | (qte_pkg::RootW'(1) << Bit);
        end else begin
            n_rem  = i_rem;
            n_root = i_root;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_lane <= i_lane;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_lane  = r_lane;
    assign o_side  = r_side;

endmodule
